>>> src/pstc_pkg.sv
// ----------------------------------------------------------------------------
// pstc_pkg
// Shared types, constants and helper functions for the pressure sensor
// temperature compensation pipeline.
// ----------------------------------------------------------------------------
package pstc_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_AC5      = 3'd0;
    localparam logic [2:0] CFG_AC6      = 3'd1;
    localparam logic [2:0] CFG_MC       = 3'd2;
    localparam logic [2:0] CFG_MD       = 3'd3;
    localparam logic [2:0] CFG_FAHR     = 3'd4;
    localparam logic [2:0] CFG_SETPOINT = 3'd5;

    // Reset values of the configuration registers.
    localparam logic        [15:0] RST_AC5      = 16'd25175;
    localparam logic        [15:0] RST_AC6      = 16'd23153;
    localparam logic signed [15:0] RST_MC       = -16'sd8711;
    localparam logic signed [15:0] RST_MD       = 16'sd2868;
    localparam logic signed [8:0]  RST_SETPOINT = 9'sd40;

    // Band codes.
    localparam logic [1:0] BAND_BELOW = 2'd0;
    localparam logic [1:0] BAND_EQUAL = 2'd1;
    localparam logic [1:0] BAND_ABOVE = 2'd2;

    // Divider geometry: a 28-bit dividend magnitude, four quotient bits a stage.
    localparam int DIV_BITS       = 4;
    localparam int DIV_NUM_W      = 28;
    localparam int DIV_DEN_W      = 18;
    localparam int DIV_STAGES     = DIV_NUM_W / DIV_BITS;

    // Reciprocals for exact truncating division by 10 and by 5.
    localparam int               RECIP_SHIFT = 30;
    localparam logic [26:0]      RECIP_10    = 27'd107374183;
    localparam logic [27:0]      RECIP_5     = 28'd214748365;

    // One stage of the divider pipeline.
    typedef struct packed {
        logic [DIV_DEN_W-1:0] rem;
        logic [DIV_NUM_W-1:0] sh;      // dividend bits out at the top, quotient in below
        logic [DIV_DEN_W-1:0] den_mag;
        logic signed [17:0]   x1;
        logic                 q_neg;
        logic                 err;
    } t_div_st;

    typedef struct packed {
        logic signed [15:0] tenths_celsius;
        logic signed [15:0] degrees_out;
        logic [1:0]         band;
        logic               divide_error;
    } t_result;

    // Four restoring division steps.
    function automatic t_div_st div_step(input t_div_st s);
        t_div_st            o;
        logic [DIV_DEN_W:0] trial;
        o = s;
        for (int b = 0; b < DIV_BITS; b++) begin
            trial = {o.rem, o.sh[DIV_NUM_W-1]};
            o.sh  = {o.sh[DIV_NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, o.den_mag}) begin
                o.rem   = DIV_DEN_W'(trial - {1'b0, o.den_mag});
                o.sh[0] = 1'b1;
            end else begin
                o.rem = trial[DIV_DEN_W-1:0];
            end
        end
        return o;
    endfunction

    // Saturate a 26-bit signed value to 16 bits.
    function automatic logic signed [15:0] sat16(input logic signed [25:0] v);
        logic signed [15:0] o;
        if (v > 26'sd32767) begin
            o = 16'sh7FFF;
        end else if (v < -26'sd32768) begin
            o = 16'sh8000;
        end else begin
            o = v[15:0];
        end
        return o;
    endfunction

endpackage

>>> src/pressure_sensor_temp_compensation_top.sv
// ----------------------------------------------------------------------------
// pressure_sensor_temp_compensation_top
// Pipelined temperature compensation of raw barometric sensor readings.
// ----------------------------------------------------------------------------
// Usage.
// A raw 16-bit temperature word enters on the input channel (i_valid,
// i_raw_reading, o_stall); a transfer takes place on a rising edge with
// i_valid high and o_stall low. One result per reading leaves on the output
// channel (o_valid, o_tenths_celsius, o_degrees_out, o_band, o_divide_error,
// i_stall), transferred on an edge with o_valid high and i_stall low.
// Calibration and mode registers are written through i_cfg_valid,
// i_cfg_index and i_cfg_data; o_cfg_ready is always high. The user must make
// writes only while no reading is in flight; the block does not enforce it.
// o_valid rises once a reading has passed every pipeline stage and the
// output register. A new reading is taken every cycle while o_stall is
// low; the 18 pipeline stages and the output register each hold
// one reading, and the divider retires four quotient bits per stage over
// seven stages.
// The output register is backed by a skid register: when the receiver
// stalls, the item leaving the pipeline is parked there and the pipeline
// freezes on the next cycle, so o_stall is a registered signal and nothing
// is lost or repeated. Reset clears every valid bit and loads the
// calibration defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module pressure_sensor_temp_compensation_top
    import pstc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration write channel.
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    // Input channel.
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [15:0]        i_raw_reading,
    // Output channel.
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_tenths_celsius,
    output logic signed [15:0] o_degrees_out,
    output logic [1:0]         o_band,
    output logic               o_divide_error
);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [15:0]        r_ac5;
    logic [15:0]        r_ac6;
    logic signed [15:0] r_mc;
    logic signed [15:0] r_md;
    logic               r_fahr;
    logic signed [8:0]  r_setpoint;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ac5      <= RST_AC5;
            r_ac6      <= RST_AC6;
            r_mc       <= RST_MC;
            r_md       <= RST_MD;
            r_fahr     <= 1'b0;
            r_setpoint <= RST_SETPOINT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_AC5:      r_ac5      <= i_cfg_data;
                CFG_AC6:      r_ac6      <= i_cfg_data;
                CFG_MC:       r_mc       <= i_cfg_data;
                CFG_MD:       r_md       <= i_cfg_data;
                CFG_FAHR:     r_fahr     <= i_cfg_data[0];
                CFG_SETPOINT: r_setpoint <= i_cfg_data[8:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline enable. The whole pipeline advances together unless the
    // skid register is occupied.
    // ------------------------------------------------------------------
    logic r_sk_valid;
    logic w_en;

    assign w_en    = !r_sk_valid;
    assign o_stall = r_sk_valid;

    // ------------------------------------------------------------------
    // Stage 1: offset the raw reading.
    // ------------------------------------------------------------------
    logic               r_s1_valid;
    logic signed [16:0] r_s1_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= i_valid;
        end
        if (w_en) begin
            r_s1_diff <= $signed({1'b0, i_raw_reading}) - $signed({1'b0, r_ac6});
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: scale by AC5.
    // ------------------------------------------------------------------
    logic               r_s2_valid;
    logic signed [32:0] r_s2_prod;
    logic signed [33:0] w_prod_full;

    assign w_prod_full = r_s1_diff * $signed({1'b0, r_ac5});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_en) begin
            r_s2_valid <= r_s1_valid;
        end
        if (w_en) begin
            r_s2_prod <= w_prod_full[32:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: X1 by arithmetic shift, divisor X1 + MD, and the operand
    // magnitudes and signs for the divider.
    // ------------------------------------------------------------------
    logic                 r_s3_valid;
    t_div_st              r_s3;
    logic signed [17:0]   w_x1;
    logic signed [18:0]   w_den;
    logic signed [18:0]   w_den_neg;
    logic signed [16:0]   w_mc_ext;
    logic signed [16:0]   w_mc_neg;
    logic [16:0]          w_mc_mag;
    logic [DIV_DEN_W-1:0] w_den_mag;

    assign w_x1      = r_s2_prod[32:15];
    assign w_den     = {w_x1[17], w_x1} + {{3{r_md[15]}}, r_md};
    assign w_den_neg = -w_den;
    assign w_den_mag = w_den[18] ? w_den_neg[DIV_DEN_W-1:0] : w_den[DIV_DEN_W-1:0];
    assign w_mc_ext  = {r_mc[15], r_mc};
    assign w_mc_neg  = -w_mc_ext;
    assign w_mc_mag  = r_mc[15] ? w_mc_neg : w_mc_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_en) begin
            r_s3_valid <= r_s2_valid;
        end
        if (w_en) begin
            r_s3.rem     <= '0;
            r_s3.sh      <= {w_mc_mag, 11'd0};
            r_s3.den_mag <= w_den_mag;
            r_s3.x1      <= w_x1;
            r_s3.q_neg   <= r_mc[15] ^ w_den[18];
            r_s3.err     <= (w_den == 19'sd0);
        end
    end

    // ------------------------------------------------------------------
    // Stages 4 to 10: restoring divider, four quotient bits per stage.
    // A zero divisor gives a meaningless quotient that stage 11 discards.
    // ------------------------------------------------------------------
    logic    r_dv_valid [DIV_STAGES];
    t_div_st r_dv       [DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_dv_valid[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_dv_valid[0] <= r_s3_valid;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_dv_valid[k] <= r_dv_valid[k-1];
            end
        end
        if (w_en) begin
            r_dv[0] <= div_step(r_s3);
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_dv[k] <= div_step(r_dv[k-1]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 11: signed X2, then T = (X1 + X2 + 8) >> 4.
    // ------------------------------------------------------------------
    t_div_st            w_dv_last;
    logic signed [28:0] w_q_pos;
    logic signed [28:0] w_x2;
    logic signed [29:0] w_sum;
    logic               r_s11_valid;
    logic signed [25:0] r_s11_t;
    logic               r_s11_err;

    assign w_dv_last = r_dv[DIV_STAGES-1];
    assign w_q_pos   = $signed({1'b0, w_dv_last.sh});
    assign w_x2      = w_dv_last.err   ? 29'sd0 :
                       w_dv_last.q_neg ? -w_q_pos : w_q_pos;
    assign w_sum     = {{12{w_dv_last.x1[17]}}, w_dv_last.x1} + {w_x2[28], w_x2} + 30'sd8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s11_valid <= 1'b0;
        end else if (w_en) begin
            r_s11_valid <= r_dv_valid[DIV_STAGES-1];
        end
        if (w_en) begin
            r_s11_t   <= w_sum[29:4];
            r_s11_err <= w_dv_last.err;
        end
    end

    // ------------------------------------------------------------------
    // Stage 12: magnitude of T and its saturated copy for the output.
    // ------------------------------------------------------------------
    logic signed [25:0] w_t_neg;
    logic               r_s12_valid;
    logic [25:0]        r_s12_tmag;
    logic               r_s12_tneg;
    logic signed [15:0] r_s12_tsat;
    logic               r_s12_err;

    assign w_t_neg = -r_s11_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s12_valid <= 1'b0;
        end else if (w_en) begin
            r_s12_valid <= r_s11_valid;
        end
        if (w_en) begin
            r_s12_tmag <= r_s11_t[25] ? w_t_neg : r_s11_t;
            r_s12_tneg <= r_s11_t[25];
            r_s12_tsat <= sat16(r_s11_t);
            r_s12_err  <= r_s11_err;
        end
    end

    // ------------------------------------------------------------------
    // Stage 13: |T| / 10 by reciprocal multiplication.
    // ------------------------------------------------------------------
    logic [52:0]        w_p10;
    logic               r_s13_valid;
    logic [22:0]        r_s13_q;
    logic               r_s13_tneg;
    logic signed [15:0] r_s13_tsat;
    logic               r_s13_err;

    assign w_p10 = 53'(r_s12_tmag) * 53'(RECIP_10);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s13_valid <= 1'b0;
        end else if (w_en) begin
            r_s13_valid <= r_s12_valid;
        end
        if (w_en) begin
            r_s13_q    <= w_p10[52:RECIP_SHIFT];
            r_s13_tneg <= r_s12_tneg;
            r_s13_tsat <= r_s12_tsat;
            r_s13_err  <= r_s12_err;
        end
    end

    // ------------------------------------------------------------------
    // Stage 14: whole degrees Celsius, truncated toward zero.
    // ------------------------------------------------------------------
    logic signed [23:0] w_q10_pos;
    logic               r_s14_valid;
    logic signed [23:0] r_s14_degc;
    logic signed [15:0] r_s14_tsat;
    logic               r_s14_err;

    assign w_q10_pos = $signed({1'b0, r_s13_q});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s14_valid <= 1'b0;
        end else if (w_en) begin
            r_s14_valid <= r_s13_valid;
        end
        if (w_en) begin
            r_s14_degc <= r_s13_tneg ? -w_q10_pos : w_q10_pos;
            r_s14_tsat <= r_s13_tsat;
            r_s14_err  <= r_s13_err;
        end
    end

    // ------------------------------------------------------------------
    // Stage 15: Fahrenheit numerator 9 * deg + 160 and its magnitude.
    // ------------------------------------------------------------------
    logic signed [27:0] w_degc_ext;
    logic signed [27:0] w_fnum;
    logic signed [27:0] w_fnum_neg;
    logic               r_s15_valid;
    logic [26:0]        r_s15_fmag;
    logic               r_s15_fneg;
    logic signed [23:0] r_s15_degc;
    logic signed [15:0] r_s15_tsat;
    logic               r_s15_err;

    assign w_degc_ext = {{4{r_s14_degc[23]}}, r_s14_degc};
    assign w_fnum     = (w_degc_ext <<< 3) + w_degc_ext + 28'sd160;
    assign w_fnum_neg = -w_fnum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s15_valid <= 1'b0;
        end else if (w_en) begin
            r_s15_valid <= r_s14_valid;
        end
        if (w_en) begin
            r_s15_fmag <= w_fnum[27] ? w_fnum_neg[26:0] : w_fnum[26:0];
            r_s15_fneg <= w_fnum[27];
            r_s15_degc <= r_s14_degc;
            r_s15_tsat <= r_s14_tsat;
            r_s15_err  <= r_s14_err;
        end
    end

    // ------------------------------------------------------------------
    // Stage 16: magnitude / 5 by reciprocal multiplication.
    // ------------------------------------------------------------------
    logic [54:0]        w_p5;
    logic               r_s16_valid;
    logic [24:0]        r_s16_q;
    logic               r_s16_fneg;
    logic signed [23:0] r_s16_degc;
    logic signed [15:0] r_s16_tsat;
    logic               r_s16_err;

    assign w_p5 = 55'(r_s15_fmag) * 55'(RECIP_5);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s16_valid <= 1'b0;
        end else if (w_en) begin
            r_s16_valid <= r_s15_valid;
        end
        if (w_en) begin
            r_s16_q    <= w_p5[54:RECIP_SHIFT];
            r_s16_fneg <= r_s15_fneg;
            r_s16_degc <= r_s15_degc;
            r_s16_tsat <= r_s15_tsat;
            r_s16_err  <= r_s15_err;
        end
    end

    // ------------------------------------------------------------------
    // Stage 17: pick the unit.
    // ------------------------------------------------------------------
    logic signed [25:0] w_q5_pos;
    logic signed [25:0] w_degf;
    logic               r_s17_valid;
    logic signed [25:0] r_s17_deg;
    logic signed [15:0] r_s17_tsat;
    logic               r_s17_err;

    assign w_q5_pos = $signed({1'b0, r_s16_q});
    assign w_degf   = r_s16_fneg ? -w_q5_pos : w_q5_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s17_valid <= 1'b0;
        end else if (w_en) begin
            r_s17_valid <= r_s16_valid;
        end
        if (w_en) begin
            r_s17_deg  <= r_fahr ? w_degf : {{2{r_s16_degc[23]}}, r_s16_degc};
            r_s17_tsat <= r_s16_tsat;
            r_s17_err  <= r_s16_err;
        end
    end

    // ------------------------------------------------------------------
    // Stage 18: band compare on the unsaturated degrees, then saturate.
    // ------------------------------------------------------------------
    logic signed [25:0] w_sp_ext;
    logic [1:0]         w_band;
    logic               r_s18_valid;
    t_result            r_s18;

    assign w_sp_ext = {{17{r_setpoint[8]}}, r_setpoint};

    always_comb begin
        if (r_s17_deg > w_sp_ext) begin
            w_band = BAND_ABOVE;
        end else if (r_s17_deg < w_sp_ext) begin
            w_band = BAND_BELOW;
        end else begin
            w_band = BAND_EQUAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s18_valid <= 1'b0;
        end else if (w_en) begin
            r_s18_valid <= r_s17_valid;
        end
        if (w_en) begin
            r_s18.tenths_celsius <= r_s17_tsat;
            r_s18.degrees_out    <= sat16(r_s17_deg);
            r_s18.band           <= w_band;
            r_s18.divide_error   <= r_s17_err;
        end
    end

    // ------------------------------------------------------------------
    // Output register with skid register. When the output is free the
    // skid contents go first, otherwise the item leaving stage 18. When
    // the output is stalled, that item is parked in the skid register.
    // ------------------------------------------------------------------
    logic    r_o_valid;
    t_result r_o;
    t_result r_sk;
    logic    w_out_free;

    assign w_out_free = !r_o_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid  <= 1'b0;
            r_sk_valid <= 1'b0;
        end else if (w_out_free) begin
            if (r_sk_valid) begin
                r_o_valid  <= 1'b1;
                r_sk_valid <= 1'b0;
            end else begin
                r_o_valid <= r_s18_valid;
            end
        end else if (r_s18_valid && w_en) begin
            r_sk_valid <= 1'b1;
        end
        if (w_out_free) begin
            r_o <= r_sk_valid ? r_sk : r_s18;
        end else if (w_en) begin
            r_sk <= r_s18;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_tenths_celsius = r_o.tenths_celsius;
    assign o_degrees_out    = r_o.degrees_out;
    assign o_band           = r_o.band;
    assign o_divide_error   = r_o.divide_error;

endmodule

>>> tb/tb_pressure_sensor_temp_compensation_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Temperature compensation regression
// Sends raw temperature words into the compensation pipeline under several
// calibration settings. Each received result is checked field by field
// against a behavioural prediction made when its reading was accepted. Both
// channels stall and idle at random, and one long receiver hold-off fills
// the pipeline until it stalls its input.
// ----------------------------------------------------------------------------
module tb_pressure_sensor_temp_compensation_top
    import pstc_pkg::*;
();

    localparam int CLK_PERIOD       = 10;
    localparam int RESET_CYCLES     = 12;
    localparam int PIPE_LATENCY     = 19;
    localparam int HOLD_CYCLES      = 80;
    localparam int RANDOM_PHASES    = 9;
    localparam int READINGS_A_PHASE = 66;
    localparam int RUN_LIMIT_CYCLES = 200_000;

    // Indexes beyond the register list; writes to them must change nothing.
    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_valid   = 1'b0;
    logic [2:0]         i_cfg_index   = CFG_AC5;
    logic [15:0]        i_cfg_data    = 16'h0000;
    logic               i_valid       = 1'b0;
    logic [15:0]        i_raw_reading = 16'h0000;
    logic               i_stall       = 1'b1;
    logic               o_cfg_ready;
    logic               o_stall;
    logic               o_valid;
    logic signed [15:0] o_tenths_celsius;
    logic signed [15:0] o_degrees_out;
    logic [1:0]         o_band;
    logic               o_divide_error;

    // Our own copy of the calibration and mode registers.
    logic [15:0]        cal_ac5     = RST_AC5;
    logic [15:0]        cal_ac6     = RST_AC6;
    logic signed [15:0] cal_mc      = RST_MC;
    logic signed [15:0] cal_md      = RST_MD;
    logic               fahr_mode   = 1'b0;
    logic signed [8:0]  setpoint    = RST_SETPOINT;

    logic [15:0] pending_readings[$];
    t_result     expected_temps[$];
    logic        reading_taken = 1'b0;
    int          tx_idle_pct   = 35;
    int          rx_idle_pct   = 53;
    logic        hold_armed    = 1'b0;
    logic        rx_hold       = 1'b0;
    int          fault_count   = 0;

    pressure_sensor_temp_compensation_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_raw_reading    (i_raw_reading),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_tenths_celsius (o_tenths_celsius),
        .o_degrees_out    (o_degrees_out),
        .o_band           (o_band),
        .o_divide_error   (o_divide_error)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // First term of the compensation. The arithmetic shift of a signed value
    // rounds towards minus infinity, as the published integer form requires.
    function automatic longint scale_offset(input logic [15:0] raw);
        return ((longint'(raw) - longint'(cal_ac6)) * longint'(cal_ac5)) >>> 15;
    endfunction

    function automatic logic signed [15:0] clamp16(input longint v);
        if (v > 32767) begin
            return 16'sh7FFF;
        end
        if (v < -32768) begin
            return 16'sh8000;
        end
        return 16'(v);
    endfunction

    // Full compensation of one reading with the current register copy. All
    // intermediate values are exact in 64 bits; only the outputs saturate,
    // and the band is decided on the unsaturated degrees.
    function automatic t_result compensate(input logic [15:0] raw);
        t_result r;
        longint  x1;
        longint  den;
        longint  x2;
        longint  tenths;
        longint  deg;
        x1  = scale_offset(raw);
        den = x1 + longint'(cal_md);
        if (den == 0) begin
            x2             = 0;
            r.divide_error = 1'b1;
        end else begin
            x2             = (longint'(cal_mc) * 2048) / den;
            r.divide_error = 1'b0;
        end
        tenths = (x1 + x2 + 8) >>> 4;
        deg    = tenths / 10;
        if (fahr_mode) begin
            deg = (9 * deg + 160) / 5;
        end
        if (deg > longint'(setpoint)) begin
            r.band = BAND_ABOVE;
        end else if (deg < longint'(setpoint)) begin
            r.band = BAND_BELOW;
        end else begin
            r.band = BAND_EQUAL;
        end
        r.tenths_celsius = clamp16(tenths);
        r.degrees_out    = clamp16(deg);
        return r;
    endfunction

    // A calibration word biased towards the unsigned and signed extremes.
    function automatic logic [15:0] pick_word();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // One register write while the pipeline is idle. The register copy only
    // changes once the transfer has actually taken place.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        case (idx)
            CFG_AC5:      cal_ac5   = data;
            CFG_AC6:      cal_ac6   = data;
            CFG_MC:       cal_mc    = signed'(data);
            CFG_MD:       cal_md    = signed'(data);
            CFG_FAHR:     fahr_mode = data[0];
            CFG_SETPOINT: setpoint  = signed'(data[8:0]);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Hold the sender back until every expected result has been received,
    // then allow for the pipeline latency before anything else changes.
    task automatic wait_drained();
        while (pending_readings.size() != 0 || i_valid || expected_temps.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (PIPE_LATENCY + 5) @(posedge i_clk);
    endtask

    // Reading driver. A new reading is offered only once the previous one
    // has been transferred, so a stalled payload is held steady. The idle
    // decision is random and never looks at o_stall.
    always @(negedge i_clk) begin : reading_driver
        if (!i_valid || reading_taken) begin
            if (i_rst_n && pending_readings.size() != 0 &&
                $urandom_range(99) >= tx_idle_pct) begin
                i_raw_reading <= pending_readings.pop_front();
                i_valid       <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure: random stalls, plus the long hold-off below.
    always @(negedge i_clk) begin : result_stall_driver
        i_stall <= rx_hold || ($urandom_range(99) < rx_idle_pct);
    end

    // Long receiver hold-off, counted here in cycles. The sender keeps
    // offering readings throughout, so the pipeline and its skid register
    // fill up and the block has to stall its input.
    initial begin : receiver_hold_off
        wait (hold_armed);
        repeat (10) @(negedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        rx_hold <= 1'b0;
    end

    // Monitor. The prediction for an accepted reading is queued before the
    // result check of the same edge, so the order of processes never matters.
    always @(posedge i_clk) begin : result_monitor
        t_result want;
        reading_taken <= i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            expected_temps.push_back(compensate(i_raw_reading));
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_temps.size() == 0) begin
                $error("result transfer with no reading outstanding");
                fault_count++;
            end else begin
                want = expected_temps.pop_front();
                if (o_tenths_celsius !== want.tenths_celsius) begin
                    $error("tenths_celsius: expected %0d, actual %0d",
                           want.tenths_celsius, o_tenths_celsius);
                    fault_count++;
                end
                if (o_degrees_out !== want.degrees_out) begin
                    $error("degrees_out: expected %0d, actual %0d",
                           want.degrees_out, o_degrees_out);
                    fault_count++;
                end
                if (o_band !== want.band) begin
                    $error("band: expected %0d, actual %0d", want.band, o_band);
                    fault_count++;
                end
                if (o_divide_error !== want.divide_error) begin
                    $error("divide_error: expected %0d, actual %0d",
                           want.divide_error, o_divide_error);
                    fault_count++;
                end
            end
        end
    end

    initial begin : stimulus
        logic [15:0] raw_v;
        logic [15:0] md_v;
        logic [15:0] sp_v;
        logic [15:0] equal_raw;
        logic        have_equal;
        t_result     equal_res;
        longint      deg_v;
        longint      aim;
        int          pick;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with the reset calibration: both extremes of the raw
        // word, mid-scale on either side, a reading equal to AC6 (first term
        // exactly zero), alternating bit patterns and the datasheet example.
        pending_readings.push_back(16'h0000);
        pending_readings.push_back(16'hFFFF);
        pending_readings.push_back(16'h8000);
        pending_readings.push_back(16'h7FFF);
        pending_readings.push_back(16'h5A71);
        pending_readings.push_back(16'hAAAA);
        pending_readings.push_back(16'h5555);
        pending_readings.push_back(16'h6CFA);
        wait_drained();

        // With AC5 at 32768 and AC6 at zero the first term equals the raw
        // word, so a reading of 1000 against MD of -1000 zeroes the divisor.
        // Readings either side make the divisor plus or minus one, which
        // drives the second term far beyond 16 bits in both directions.
        write_reg(CFG_AC5, 16'h8000);
        write_reg(CFG_AC6, 16'h0000);
        write_reg(CFG_MC, 16'h8000);
        write_reg(CFG_MD, 16'hFC18);
        write_reg(CFG_FAHR, 16'hFFFE);
        write_reg(CFG_SETPOINT, 16'h0028);
        // Writes past the end of the register list must be ignored.
        write_reg(CFG_SPARE_LO, 16'hFFFF);
        write_reg(CFG_SPARE_HI, 16'h1234);
        @(posedge i_clk);
        pending_readings.push_back(16'd1000);
        pending_readings.push_back(16'd999);
        pending_readings.push_back(16'd1001);
        pending_readings.push_back(16'h0000);
        pending_readings.push_back(16'hFFFF);
        wait_drained();

        // Every register at its top value, Fahrenheit on, and the lowest
        // setpoint carried in the low nine bits of a wider word.
        write_reg(CFG_AC5, 16'hFFFF);
        write_reg(CFG_AC6, 16'hFFFF);
        write_reg(CFG_MC, 16'h7FFF);
        write_reg(CFG_MD, 16'h7FFF);
        write_reg(CFG_FAHR, 16'hFFFF);
        write_reg(CFG_SETPOINT, 16'hFF00);
        @(posedge i_clk);
        pending_readings.push_back(16'h0000);
        pending_readings.push_back(16'hFFFF);
        pending_readings.push_back(16'h8000);
        pending_readings.push_back(16'h0001);
        pending_readings.push_back(16'h5A71);
        wait_drained();

        // Random part. Three phases with the sender idling more lightly than
        // the receiver, three the other way round, and three with no idling
        // at all; the first of those also carries the long hold-off.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase / 3)
                0: begin
                    tx_idle_pct = 35;
                    rx_idle_pct = 53;
                end
                1: begin
                    tx_idle_pct = 53;
                    rx_idle_pct = 35;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase

            // Small MD values keep a zero divisor within reach.
            md_v = ($urandom_range(2) == 0) ? 16'($urandom_range(4000)) - 16'd2000
                                            : pick_word();
            write_reg(CFG_AC5, pick_word());
            write_reg(CFG_AC6, pick_word());
            write_reg(CFG_MC, pick_word());
            write_reg(CFG_MD, md_v);
            write_reg(CFG_FAHR, 16'($urandom));

            // The setpoint is written last so that it can be set to the
            // degrees of a chosen reading, which gives the equal band.
            have_equal = 1'b0;
            equal_raw  = 16'($urandom);
            pick       = $urandom_range(3);
            sp_v       = 16'($urandom);
            if (pick == 0) begin
                sp_v = (sp_v & 16'hFE00) | 16'h0100;
            end else if (pick == 1) begin
                sp_v = (sp_v & 16'hFE00) | 16'h00FF;
            end else if (pick == 2) begin
                equal_res = compensate(equal_raw);
                deg_v     = equal_res.degrees_out;
                if (deg_v >= -256 && deg_v <= 255) begin
                    sp_v       = 16'(deg_v);
                    have_equal = 1'b1;
                end
            end
            write_reg(CFG_SETPOINT, sp_v);
            @(posedge i_clk);

            for (int n = 0; n < READINGS_A_PHASE; n++) begin
                pick  = $urandom_range(99);
                raw_v = 16'($urandom);
                if (pick >= 70 && pick < 80) begin
                    // Close to AC6, where the first term is small.
                    raw_v = cal_ac6 + 16'($urandom_range(64)) - 16'd32;
                end else if (pick >= 80 && pick < 88 && cal_ac5 != 16'h0000) begin
                    // Aim for a zero divisor: search next to the reading
                    // that would make the first term equal to minus MD.
                    aim = longint'(cal_ac6) -
                          (longint'(cal_md) * 32768) / longint'(cal_ac5);
                    for (int k = -2; k <= 2; k++) begin
                        if (aim + k >= 0 && aim + k <= 65535 &&
                            scale_offset(16'(aim + k)) == -longint'(cal_md)) begin
                            raw_v = 16'(aim + k);
                        end
                    end
                end else if (pick >= 88 && pick < 94 && have_equal) begin
                    raw_v = equal_raw;
                end else if (pick >= 94) begin
                    raw_v = (pick & 1) ? 16'hFFFF : 16'h0000;
                end
                pending_readings.push_back(raw_v);
            end

            if (phase == 6) begin
                hold_armed = 1'b1;
            end
            // The sender pauses here until every expected result has come.
            wait_drained();
        end

        if (fault_count == 0) begin
            $display("pressure_sensor_temp_compensation_top regression: pass");
        end else begin
            $display("pressure_sensor_temp_compensation_top regression: fail");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin : run_limit
        #(RUN_LIMIT_CYCLES * CLK_PERIOD);
        $display("pressure_sensor_temp_compensation_top regression: fail");
        $finish;
    end

endmodule
